// ----- design/i2c_bit_level_master_macros.svh -----
// assertion helpers for the asserting design file
`ifndef I2C_BIT_LEVEL_MASTER_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define I2CBL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2c bit engine: same-cycle check failed");

// next-cycle implication, checked out of reset
`define I2CBL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2c bit engine: next-cycle check failed");

`endif

// ----- design/i2cbl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package i2cbl_pkg;

  // bus phases, one-hot
  typedef enum logic [10:0] {
    PH_IDLE  = 11'b000_0000_0001,
    PH_S1    = 11'b000_0000_0010,
    PH_S2    = 11'b000_0000_0100,
    PH_S3    = 11'b000_0000_1000,
    PH_P1    = 11'b000_0001_0000,
    PH_P2    = 11'b000_0010_0000,
    PH_BSET  = 11'b000_0100_0000,
    PH_BHIGH = 11'b000_1000_0000,
    PH_BLOW  = 11'b001_0000_0000,
    PH_RHIGH = 11'b010_0000_0000,
    PH_RLOW  = 11'b100_0000_0000
  } phase_e;

  // command codes
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_STOP  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam int unsigned       BitsPerByte = 8;
  localparam logic [15:0]       PhaseTicksReset = 16'd100;

  // one result item
  typedef struct packed {
    logic [2:0] pad;
    logic       slave_nack;
    logic [7:0] read_data;
    logic       cmd_done;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } result_t;

endpackage

`default_nettype wire

// ----- design/i2c_bit_level_master.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+------------------------------
// s_axis    | in        | s_axis_tvalid/tready   | one bus tick with command
// m_axis    | out       | m_axis_tvalid/tready   | line drive and status after it
// cfg       | in        | cfg_valid/cfg_ready    | phase_ticks
//
// one tick transaction per clock cycle while the output is not stalled; the engine
// state and the output register both load on the clock edge that accepts the tick
// reset brings the engine to idle with both lines released, phase_ticks 100
// a stalled output holds its result and stops input acceptance until taken
// cfg is always ready and takes effect on the next tick

`include "i2c_bit_level_master_macros.svh"

module i2c_bit_level_master
  import i2cbl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [0] cmd_valid, [8:1] write_byte, [9] master_nack, [10] sda_in, [15:11] zero
  input  wire logic [15:0] s_axis_tdata_i,
  // [1:0] req_type
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] cmd_done, [11:4] read_data,
  // [12] slave_nack, [15:13] zero
  output logic [15:0]      m_axis_tdata_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  // input fields
  logic       cmd_valid;
  logic [1:0] req_type;
  logic [7:0] write_byte;
  logic       master_nack;
  logic       sda_in;

  assign cmd_valid   = s_axis_tdata_i[0];
  assign write_byte  = s_axis_tdata_i[8:1];
  assign master_nack = s_axis_tdata_i[9];
  assign sda_in      = s_axis_tdata_i[10];
  assign req_type    = s_axis_tuser_i;

  // engine state
  logic [15:0] phase_ticks_q;
  phase_e      phase_q, phase_d;
  logic [1:0]  kind_q, kind_d;
  logic [3:0]  bit_count_q, bit_count_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] tick_q, tick_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        nack_q, nack_d;
  logic [7:0]  read_hold_q, read_hold_d;
  logic        ack_choice_q, ack_choice_d;

  // output register
  logic        m_valid_q;
  result_t     m_data_q, m_data_d;

  logic        s_accept;
  logic        done;
  logic        enter_en;
  phase_e      enter_ph;
  logic [15:0] limit;
  logic [15:0] tick_inc;
  logic        phase_end;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // phase length, zero acts as one
  assign limit     = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;
  assign tick_inc  = tick_q + 16'd1;
  assign phase_end = (tick_inc >= limit);

  // next engine state for one tick
  always_comb begin
    phase_d      = phase_q;
    kind_d       = kind_q;
    bit_count_d  = bit_count_q;
    shift_d      = shift_q;
    tick_d       = tick_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    nack_d       = nack_q;
    read_hold_d  = read_hold_q;
    ack_choice_d = ack_choice_q;
    done         = 1'b0;
    enter_en     = 1'b0;
    enter_ph     = PH_IDLE;

    if (phase_q == PH_IDLE) begin
      // command start
      if (cmd_valid) begin
        kind_d      = req_type;
        bit_count_d = '0;
        enter_en    = 1'b1;
        unique case (req_type)
          KIND_START: enter_ph = PH_S1;
          KIND_STOP:  enter_ph = PH_P1;
          KIND_WRITE: begin
            shift_d  = write_byte;
            enter_ph = PH_BSET;
          end
          default: begin
            shift_d      = '0;
            ack_choice_d = master_nack;
            enter_ph     = PH_RHIGH;
          end
        endcase
      end
    end else begin
      tick_d = tick_inc;
      if (phase_end) begin
        // phase transitions
        unique case (phase_q)
          PH_S1: begin
            enter_en = 1'b1;
            enter_ph = PH_S2;
          end
          PH_S2: begin
            enter_en = 1'b1;
            enter_ph = PH_S3;
          end
          PH_P1: begin
            enter_en = 1'b1;
            enter_ph = PH_P2;
          end
          PH_BSET: begin
            enter_en = 1'b1;
            enter_ph = PH_BHIGH;
          end
          PH_BHIGH: begin
            if (bit_count_q >= 4'(BitsPerByte) && kind_q == KIND_WRITE) begin
              nack_d = sda_in;
            end
            enter_en = 1'b1;
            enter_ph = PH_BLOW;
          end
          PH_BLOW: begin
            if (bit_count_q < 4'(BitsPerByte)) begin
              bit_count_d = bit_count_q + 4'd1;
              shift_d     = {shift_q[6:0], 1'b0};
              enter_en    = 1'b1;
              enter_ph    = PH_BSET;
            end else begin
              sda_d = 1'b1;
              done  = 1'b1;
            end
          end
          PH_RHIGH: begin
            shift_d  = {shift_q[6:0], sda_in};
            enter_en = 1'b1;
            enter_ph = PH_RLOW;
          end
          PH_RLOW: begin
            bit_count_d = bit_count_q + 4'd1;
            enter_en    = 1'b1;
            if (bit_count_d >= 4'(BitsPerByte)) begin
              read_hold_d = shift_q;
              enter_ph    = PH_BSET;
            end else begin
              enter_ph = PH_RHIGH;
            end
          end
          default: done = 1'b1;
        endcase
        if (done) begin
          phase_d = PH_IDLE;
          tick_d  = '0;
        end
      end
    end

    // line levels on phase entry
    if (enter_en) begin
      phase_d = enter_ph;
      tick_d  = '0;
      unique case (enter_ph)
        PH_S1: begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end
        PH_S2: sda_d = 1'b0;
        PH_S3: scl_d = 1'b0;
        PH_P1: begin
          scl_d = 1'b1;
          sda_d = 1'b0;
        end
        PH_P2: sda_d = 1'b1;
        PH_BSET: begin
          scl_d = 1'b0;
          if (bit_count_d < 4'(BitsPerByte)) begin
            sda_d = shift_d[7];
          end else if (kind_d == KIND_WRITE) begin
            sda_d = 1'b1;
          end else begin
            sda_d = ack_choice_d;
          end
        end
        PH_BHIGH: scl_d = 1'b1;
        PH_BLOW:  scl_d = 1'b0;
        PH_RHIGH: begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end
        PH_RLOW: scl_d = 1'b0;
        default: ;
      endcase
    end
  end

  // result of this tick
  always_comb begin
    m_data_d            = '0;
    m_data_d.scl_out    = scl_d;
    m_data_d.sda_out    = sda_d;
    m_data_d.busy_res   = (phase_d != PH_IDLE);
    m_data_d.cmd_done   = done;
    m_data_d.read_data  = read_hold_d;
    m_data_d.slave_nack = nack_d;
  end

  // engine registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      kind_q       <= KIND_START;
      bit_count_q  <= '0;
      shift_q      <= '0;
      tick_q       <= '0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      nack_q       <= 1'b0;
      read_hold_q  <= '0;
      ack_choice_q <= 1'b0;
    end else if (s_accept) begin
      phase_q      <= phase_d;
      kind_q       <= kind_d;
      bit_count_q  <= bit_count_d;
      shift_q      <= shift_d;
      tick_q       <= tick_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      nack_q       <= nack_d;
      read_hold_q  <= read_hold_d;
      ack_choice_q <= ack_choice_d;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      phase_ticks_q <= cfg_data_i;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      m_data_q <= m_data_d;
    end
  end

  // checks
  `I2CBL_ASSERT_IMPL(a_bit_count_range, 1'b1, bit_count_q <= 4'(BitsPerByte))
  `I2CBL_ASSERT_NEXT(a_done_goes_idle, s_accept && done, phase_q == PH_IDLE)
  `I2CBL_ASSERT_NEXT(a_busy_matches, s_accept, m_data_q.busy_res == (phase_q != PH_IDLE))

endmodule

`default_nettype wire
